[sv/tdwm_pkg.sv]
package tdwm_pkg;

	typedef enum logic [1:0] {
		REQ_WR_TRANS  = 2'd0,
		REQ_WR_ACCEPT = 2'd1,
		REQ_CHAR      = 2'd2,
		REQ_EOW       = 2'd3
	} req_t;

	// state numbers that can ever be stored or started from
	localparam int STATE_W = 6;

	// transition entry: low bits hold the next state, top bit set means none
	localparam int TRANS_W = 7;
	localparam logic [TRANS_W-1:0] NO_TRANS = 7'h7F;

	localparam int COL_LETTER = 1;
	localparam int COL_DIGIT  = 2;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
			(c == CH_USCORE);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
	endfunction

endpackage

[sv/table_dfa_word_matcher_top.sv]
// Table-driven automaton matcher for a stream of words.
// Input channel (in_valid/in_ready) carries one word per item: a transition
// write, an accept-flag write, one character, or an end-of-word marker.
// Output channel (out_valid/out_ready) carries one word per end-of-word:
// accepted and rejected_early for the word that just ended.
// Config channel (cfg_valid/cfg_ready) loads start_state; it is always ready
// and takes effect at the next word boundary.
// Throughput: one input word per cycle once the reset sweep is done and while
// no end-of-word is held for a stalled receiver. The limit is the state loop:
// the registered table read feeds the next-state select, which drives the
// read address of the next character in the same cycle.
// A result is loaded into the output register when its end-of-word leaves
// the lookup stage; the table read happens at the edge that accepts it.
// Reset: the transition tables are swept to "no transition" and the accept
// table to zero, one entry per cycle; in_ready stays low for that sweep.
// When the receiver stalls, the result waits in the output register; input
// keeps flowing until a second end-of-word reaches the lookup stage, which
// then holds and drops in_ready until the result is taken.
module table_dfa_word_matcher_top
	import tdwm_pkg::*;
#(
	parameter int STATE_COUNT  = 64,
	parameter int SYMBOL_COUNT = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [5:0]        state_index,
	input  logic [6:0]        symbol_index,
	input  logic signed [6:0] target_state,
	input  logic              accept_bit,
	input  logic [7:0]        char_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic              rejected_early,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [5:0]        start_state
);

	localparam int ST_W  = $clog2(STATE_COUNT);
	localparam int SYM_W = $clog2(SYMBOL_COUNT);
	localparam int AW    = ST_W + SYM_W;
	localparam int DEPTH = STATE_COUNT * (1 << SYM_W);

	// clear sweep
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	// architectural state
	logic [STATE_W-1:0] start_q;
	logic [STATE_W-1:0] state_q;
	logic               dead_q;

	// lookup stage
	logic s1_valid_q;
	req_t s1_req_s1;
	logic s1_letter_s1;
	logic s1_digit_s1;
	logic s1_dir_ok_s1;
	logic s1_st_ok_s1;

	// result register
	logic out_valid_q;
	logic accepted_q;
	logic rejected_q;

	logic         in_fire;
	logic         s1_fire;
	req_t         in_req;
	logic [STATE_W-1:0] state_d;
	logic         dead_d;
	logic         res_vld;
	logic         res_acc;
	logic         res_rej;

	logic [TRANS_W-1:0] dir_rd;
	logic [TRANS_W-1:0] let_rd;
	logic [TRANS_W-1:0] dig_rd;
	logic               acc_rd;
	logic               dir_hit;
	logic               let_hit;
	logic               dig_hit;

	logic [ST_W+STATE_W-1:0] rd_st_wide;
	logic [ST_W+STATE_W-1:0] wr_st_wide;
	logic [SYM_W+7:0]        ch_wide;
	logic [SYM_W+6:0]        sym_wide;
	logic [ST_W-1:0]         rd_st;
	logic [ST_W-1:0]         wr_st;
	logic [SYM_W-1:0]        ch_col;
	logic [SYM_W-1:0]        wr_col;

	logic [AW-1:0]      tr_waddr;
	logic [TRANS_W-1:0] tr_wdata;
	logic               tr_we;
	logic [ST_W-1:0]    acc_waddr;
	logic               acc_wdata;
	logic               acc_we;
	logic               wr_in_range;
	logic               target_ok;

	assign in_req    = req_t'(req_type);
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- handshake
	assign s1_fire  = s1_valid_q && (s1_req_s1 != REQ_EOW || !out_valid_q || out_ready);
	assign in_ready = !clr_busy_q && (!s1_valid_q || s1_fire);
	assign in_fire  = in_valid && in_ready;

	// ---------------------------------------------------------------- next state
	assign dir_hit = s1_dir_ok_s1 && !dir_rd[TRANS_W-1];
	assign let_hit = s1_st_ok_s1 && s1_letter_s1 && !let_rd[TRANS_W-1];
	assign dig_hit = s1_st_ok_s1 && s1_digit_s1 && !dig_rd[TRANS_W-1];

	always_comb begin
		state_d = state_q;
		dead_d  = dead_q;
		res_vld = 1'b0;
		res_acc = 1'b0;
		res_rej = 1'b0;
		if (s1_valid_q) begin
			unique case (s1_req_s1)
				REQ_CHAR: begin
					if (!dead_q) begin
						if (dir_hit) begin
							state_d = dir_rd[STATE_W-1:0];
						end else if (let_hit) begin
							state_d = let_rd[STATE_W-1:0];
						end else if (dig_hit) begin
							state_d = dig_rd[STATE_W-1:0];
						end else begin
							dead_d = 1'b1;
						end
					end
				end
				REQ_EOW: begin
					res_vld = 1'b1;
					res_acc = !dead_q && s1_st_ok_s1 && acc_rd;
					res_rej = dead_q;
					state_d = start_q;
					dead_d  = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- addresses
	// state_d is the state the accepted word sees: s1 commits in the same edge
	assign rd_st_wide = {{ST_W{1'b0}}, state_d};
	assign rd_st      = rd_st_wide[ST_W-1:0];
	assign wr_st_wide = {{ST_W{1'b0}}, state_index};
	assign wr_st      = wr_st_wide[ST_W-1:0];
	assign ch_wide    = {{SYM_W{1'b0}}, char_code};
	assign ch_col     = ch_wide[SYM_W-1:0];
	assign sym_wide   = {{SYM_W{1'b0}}, symbol_index};
	assign wr_col     = sym_wide[SYM_W-1:0];

	assign wr_in_range = (32'(state_index) < STATE_COUNT) && (32'(symbol_index) < SYMBOL_COUNT);
	assign target_ok   = !target_state[6] && (32'(target_state[5:0]) < STATE_COUNT);

	always_comb begin
		if (clr_busy_q) begin
			tr_we     = 1'b1;
			tr_waddr  = clr_cnt_q;
			tr_wdata  = NO_TRANS;
			acc_we    = 1'b1;
			acc_waddr = clr_cnt_q[AW-1:SYM_W];
			acc_wdata = 1'b0;
		end else begin
			tr_we     = in_fire && in_req == REQ_WR_TRANS && wr_in_range;
			tr_waddr  = {wr_st, wr_col};
			tr_wdata  = target_ok ? {1'b0, target_state[5:0]} : NO_TRANS;
			acc_we    = in_fire && in_req == REQ_WR_ACCEPT && 32'(state_index) < STATE_COUNT;
			acc_waddr = wr_st;
			acc_wdata = accept_bit;
		end
	end

	// ---------------------------------------------------------------- tables
	// three copies of the transition table: direct, letter and digit columns
	tdwm_ram #(.WIDTH(TRANS_W), .DEPTH(DEPTH)) u_tr_dir (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_waddr),
		.wdata (tr_wdata),
		.re    (in_fire),
		.raddr ({rd_st, ch_col}),
		.rdata (dir_rd)
	);

	tdwm_ram #(.WIDTH(TRANS_W), .DEPTH(DEPTH)) u_tr_let (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_waddr),
		.wdata (tr_wdata),
		.re    (in_fire),
		.raddr ({rd_st, SYM_W'(COL_LETTER)}),
		.rdata (let_rd)
	);

	tdwm_ram #(.WIDTH(TRANS_W), .DEPTH(DEPTH)) u_tr_dig (
		.clk   (clk),
		.we    (tr_we),
		.waddr (tr_waddr),
		.wdata (tr_wdata),
		.re    (in_fire),
		.raddr ({rd_st, SYM_W'(COL_DIGIT)}),
		.rdata (dig_rd)
	);

	tdwm_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (in_fire),
		.raddr (rd_st),
		.rdata (acc_rd)
	);

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= start_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			dead_q  <= 1'b0;
		end else if (s1_fire) begin
			state_q <= state_d;
			dead_q  <= dead_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_req_s1    <= in_req;
			s1_letter_s1 <= is_letter(char_code);
			s1_digit_s1  <= is_digit(char_code);
			s1_st_ok_s1  <= 32'(state_d) < STATE_COUNT;
			s1_dir_ok_s1 <= (32'(state_d) < STATE_COUNT) && (32'(char_code) < SYMBOL_COUNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_vld) begin
			accepted_q <= res_acc;
			rejected_q <= res_rej;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign rejected_early = rejected_q;

	// ---------------------------------------------------------------- checks
	a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("input taken during table clear");

	a_result_from_eow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q && s1_req_s1 == REQ_EOW))
		else $error("result without end-of-word");

	a_accept_excludes_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(accepted_q && rejected_q))
		else $error("word both accepted and rejected");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(state_q) && $stable(dead_q)))
		else $error("state moved while lookup stage stalled");

endmodule

[sv/tdwm_ram.sv]
module tdwm_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
